// ===== rtl/cfod_pkg.sv =====
// Shared constants, codes and types for the class FIFO with oldest-first dequeue.
package cfod_pkg;

  // Default sizing of the block
  localparam int NUM_CLASSES_DEF = 2;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;

  // Fixed widths of the request and result fields
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int IO_TAG_W = 16;
  localparam int STAMP_W  = 64;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ       = 2'd0,
    REQ_DEQ_ANY   = 2'd1,
    REQ_DEQ_CLASS = 2'd2
  } req_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Occupancy flags reported by one class queue
  typedef struct packed {
    logic nonempty;
    logic full;
  } q_flags_t;

endpackage

// ===== rtl/cfod_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cfod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port (read returns old data on a collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cfod_queue.sv =====
// One class queue: entry RAM plus a head register and a prefetched next entry.
module cfod_queue #(
  parameter int QUEUE_DEPTH = cfod_pkg::QUEUE_DEPTH_DEF,
  parameter int ENT_W       = cfod_pkg::STAMP_W + cfod_pkg::TAG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               enq,
  input  logic               pop,
  input  logic [ENT_W-1:0]   wr_ent,
  output logic [ENT_W-1:0]   head_ent,
  output cfod_pkg::q_flags_t flags
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [PTR_W-1:0] head_ptr_r, head_ptr_nxt;
  logic [PTR_W-1:0] tail_ptr_r, tail_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [ENT_W-1:0] head_ent_r;
  logic             byp_vld_r;
  logic [ENT_W-1:0] byp_ent_r;
  logic [ENT_W-1:0] ram_q;
  logic [ENT_W-1:0] second_ent;
  logic [PTR_W-1:0] rd_addr;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // pointer and fill count updates
  always_comb begin
    head_ptr_nxt = pop ? next_ptr(head_ptr_r) : head_ptr_r;
    tail_ptr_nxt = enq ? next_ptr(tail_ptr_r) : tail_ptr_r;
    count_nxt    = count_r;
    if (enq && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !enq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // prefetch the entry behind the next head; a same-cycle write is bypassed
  assign rd_addr    = next_ptr(head_ptr_nxt);
  assign second_ent = byp_vld_r ? byp_ent_r : ram_q;

  cfod_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (enq),
    .waddr (tail_ptr_r),
    .wdata (wr_ent),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_ptr_r <= '0;
      tail_ptr_r <= '0;
      count_r    <= '0;
      byp_vld_r  <= 1'b0;
    end else begin
      head_ptr_r <= head_ptr_nxt;
      tail_ptr_r <= tail_ptr_nxt;
      count_r    <= count_nxt;
      byp_vld_r  <= enq && (tail_ptr_r == rd_addr);
    end
  end

  // head entry and bypass data
  always_ff @(posedge clk) begin
    byp_ent_r <= wr_ent;
    if (enq && count_r == '0) begin
      head_ent_r <= wr_ent;
    end else if (pop && count_r > CNT_W'(1)) begin
      head_ent_r <= second_ent;
    end
  end

  assign head_ent       = head_ent_r;
  assign flags.nonempty = (count_r != '0);
  assign flags.full     = (count_r == CNT_W'(QUEUE_DEPTH));

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0) && !enq)
    else $error("pop from empty queue or with a push");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    enq |=> (count_r == $past(count_r) + CNT_W'(1)) && (count_r != '0))
    else $error("push did not grow the fill count");

endmodule

// ===== rtl/cfod_pick.sv =====
// Oldest-head arbiter: parallel pairwise stamp compare, lowest class on ties.
module cfod_pick #(
  parameter int NUM_CLASSES = cfod_pkg::NUM_CLASSES_DEF
) (
  input  logic [NUM_CLASSES-1:0]       head_vld,
  input  logic [cfod_pkg::STAMP_W-1:0] head_stamp [NUM_CLASSES],
  output logic                         found,
  output logic [$clog2(NUM_CLASSES)-1:0] win_idx
);

  localparam int CLS_W = $clog2(NUM_CLASSES);

  logic [NUM_CLASSES-1:0] win;

  // a class wins when its head is older than every other valid head, or ties only with higher classes
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      win[c] = head_vld[c];
      for (int d = 0; d < NUM_CLASSES; d++) begin
        if (d != c && head_vld[d]) begin
          if (d < c) begin
            win[c] = win[c] && (head_stamp[c] < head_stamp[d]);
          end else begin
            win[c] = win[c] && (head_stamp[c] <= head_stamp[d]);
          end
        end
      end
    end
  end

  // encode the winner
  always_comb begin
    win_idx = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (win[c]) begin
        win_idx = CLS_W'(c);
      end
    end
  end

  assign found = |head_vld;

endmodule

// ===== rtl/class_fifo_oldest_first_dequeue_core.sv =====
// Top level: per-class FIFOs with oldest-first dequeue, request and result registers.
//
//  channel | ports                                       | direction
//  --------+---------------------------------------------+----------
//  request | in_valid in_stall in_req_type in_item_class |  in
//          | in_item_tag                                 |
//  result  | out_valid out_stall out_status out_class    |  out
//          | out_tag                                     |
//
// One request per cycle while out_stall does not hold the result; a request passes the
// request register, then one execute pass into the result register, where it is valid.
// The head stamps of all class queues are compared in one parallel pass.
// Reset clears pointers, fill counts, the arrival counter and the valids; entry
// RAM contents are not cleared and need no clearing pass.
// out_stall holds the result; in_stall rises while a request waits on it.
module class_fifo_oldest_first_dequeue_core #(
  parameter int NUM_CLASSES = cfod_pkg::NUM_CLASSES_DEF,
  parameter int QUEUE_DEPTH = cfod_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = cfod_pkg::TAG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cfod_pkg::REQ_W-1:0]    in_req_type,
  input  logic                          in_item_class,
  input  logic [cfod_pkg::IO_TAG_W-1:0] in_item_tag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cfod_pkg::STATUS_W-1:0] out_status,
  output logic                          out_class,
  output logic [cfod_pkg::IO_TAG_W-1:0] out_tag
);

  localparam int CLS_W   = $clog2(NUM_CLASSES);
  localparam int STAMP_W = cfod_pkg::STAMP_W;
  localparam int ENT_W   = STAMP_W + TAG_BITS;

  // request register
  logic                          req_vld_r;
  logic [cfod_pkg::REQ_W-1:0]    req_type_r;
  logic                          req_class_r;
  logic [cfod_pkg::IO_TAG_W-1:0] req_tag_r;

  // result register
  logic                          out_valid_r;
  logic [cfod_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_class_r;
  logic [cfod_pkg::IO_TAG_W-1:0] out_tag_r;

  logic [STAMP_W-1:0] arrival_r;

  logic                   go;
  logic [CLS_W-1:0]       cls_idx;
  logic [NUM_CLASSES-1:0] nonempty_vec, full_vec, enq_vec, pop_vec;
  logic [ENT_W-1:0]       head_ent [NUM_CLASSES];
  logic [STAMP_W-1:0]     head_stamp [NUM_CLASSES];
  cfod_pkg::q_flags_t     flags [NUM_CLASSES];
  logic                   any_found;
  logic [CLS_W-1:0]       any_idx;
  logic [ENT_W-1:0]       wr_ent;
  logic [TAG_BITS-1:0]    pop_tag;

  cfod_pkg::status_t      status_nxt;
  logic                   do_enq, do_pop;
  logic [CLS_W-1:0]       pop_idx;

  // handshake
  assign go       = req_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = req_vld_r && !go;
  assign cls_idx  = CLS_W'(req_class_r);
  assign wr_ent   = {arrival_r, TAG_BITS'(req_tag_r)};

  // class queues
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_cls
    assign enq_vec[c]    = go && do_enq && (cls_idx == CLS_W'(c));
    assign pop_vec[c]    = go && do_pop && (pop_idx == CLS_W'(c));
    assign nonempty_vec[c] = flags[c].nonempty;
    assign full_vec[c]   = flags[c].full;
    assign head_stamp[c] = head_ent[c][ENT_W-1:TAG_BITS];

    cfod_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ENT_W       (ENT_W)
    ) u_queue (
      .clk      (clk),
      .rst_n    (rst_n),
      .enq      (enq_vec[c]),
      .pop      (pop_vec[c]),
      .wr_ent   (wr_ent),
      .head_ent (head_ent[c]),
      .flags    (flags[c])
    );
  end

  cfod_pick #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_pick (
    .head_vld   (nonempty_vec),
    .head_stamp (head_stamp),
    .found      (any_found),
    .win_idx    (any_idx)
  );

  // request decode
  always_comb begin
    status_nxt = cfod_pkg::ST_EMPTY;
    do_enq     = 1'b0;
    do_pop     = 1'b0;
    pop_idx    = cls_idx;
    unique case (req_type_r)
      cfod_pkg::REQ_ENQ: begin
        if (full_vec[cls_idx]) begin
          status_nxt = cfod_pkg::ST_FULL;
        end else begin
          status_nxt = cfod_pkg::ST_OK;
          do_enq     = 1'b1;
        end
      end
      cfod_pkg::REQ_DEQ_ANY: begin
        if (any_found) begin
          status_nxt = cfod_pkg::ST_OK;
          do_pop     = 1'b1;
          pop_idx    = any_idx;
        end
      end
      cfod_pkg::REQ_DEQ_CLASS: begin
        if (nonempty_vec[cls_idx]) begin
          status_nxt = cfod_pkg::ST_OK;
          do_pop     = 1'b1;
        end
      end
      default: begin
        status_nxt = cfod_pkg::ST_EMPTY;
      end
    endcase
  end

  assign pop_tag = head_ent[pop_idx][TAG_BITS-1:0];

  // request register and arrival counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      arrival_r <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        req_vld_r <= 1'b1;
      end else if (go) begin
        req_vld_r <= 1'b0;
      end
      if (go && do_enq) begin
        arrival_r <= arrival_r + STAMP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_type_r  <= in_req_type;
      req_class_r <= in_item_class;
      req_tag_r   <= in_item_tag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_status_r <= status_nxt;
      out_class_r  <= do_pop ? pop_idx[0] : 1'b0;
      out_tag_r    <= do_pop ? cfod_pkg::IO_TAG_W'(pop_tag) : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_class  = out_class_r;
  assign out_tag    = out_tag_r;

  // checks
  a_arrival_step: assert property (@(posedge clk) disable iff (!rst_n)
    (go && do_enq) |=> (arrival_r == $past(arrival_r) + STAMP_W'(1)))
    else $error("arrival counter did not advance on enqueue");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != cfod_pkg::ST_OK) |-> (out_tag_r == '0 && !out_class_r))
    else $error("refused request carries item fields");

  a_pop_target: assert property (@(posedge clk) disable iff (!rst_n)
    (go && do_pop) |-> (nonempty_vec[pop_idx] && $onehot(pop_vec) && (enq_vec == '0)))
    else $error("dequeue aimed at an empty class");

endmodule

// ===== tb/class_fifo_oldest_first_dequeue_core_tb.sv =====
// Testbench for the class FIFO core: directed table, then random traffic against a predictor.
`timescale 1ns / 100ps

module class_fifo_oldest_first_dequeue_core_tb;

  localparam int NCLS       = cfod_pkg::NUM_CLASSES_DEF;
  localparam int QDEPTH     = cfod_pkg::QUEUE_DEPTH_DEF;
  localparam int RAND_ITEMS = 900;
  localparam int DRAIN_CYC  = 10;
  localparam int RUN_LIMIT  = 5_000_000;

  // Request code the block does not define
  localparam logic [cfod_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Receiver stall patterns
  localparam int STALL_NONE   = 0;
  localparam int STALL_RANDOM = 1;
  localparam int STALL_HEAVY  = 2;
  localparam int STALL_PERIOD = 3;

  // Random traffic mixes
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  typedef struct packed {
    cfod_pkg::status_t             status;
    logic                          cls;
    logic [cfod_pkg::IO_TAG_W-1:0] tag;
  } result_t;

  typedef struct {
    logic [cfod_pkg::REQ_W-1:0]    req;
    logic                          cls;
    logic [cfod_pkg::IO_TAG_W-1:0] tag;
    bit                            typed;
    result_t                       want;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [cfod_pkg::REQ_W-1:0]    in_req_type = cfod_pkg::REQ_ENQ;
  logic                          in_item_class = 1'b0;
  logic [cfod_pkg::IO_TAG_W-1:0] in_item_tag = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [cfod_pkg::STATUS_W-1:0] out_status;
  logic                          out_class;
  logic [cfod_pkg::IO_TAG_W-1:0] out_tag;

  class_fifo_oldest_first_dequeue_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_item_class (in_item_class),
    .in_item_tag   (in_item_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_class     (out_class),
    .out_tag       (out_tag)
  );

  always #6 clk = ~clk;

  // Predictor state: per-class ring of tags and arrival stamps
  logic [cfod_pkg::IO_TAG_W-1:0] tag_ring   [NCLS][QDEPTH];
  logic [cfod_pkg::STAMP_W-1:0]  stamp_ring [NCLS][QDEPTH];
  int                            ring_head  [NCLS];
  int                            ring_tail  [NCLS];
  int                            ring_fill  [NCLS];
  logic [cfod_pkg::STAMP_W-1:0]  next_stamp;

  result_t   pending_results[$];
  dir_row_t  dir_table[$];
  result_t   oldest_result;
  int        mismatch_count = 0;
  int        burst_left = 0;

  task automatic report_mismatch(string what, logic [cfod_pkg::IO_TAG_W-1:0] got,
                                 logic [cfod_pkg::IO_TAG_W-1:0] want);
    $display("%0t ns: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Expected result of one request; advances the predictor state
  function automatic result_t predict_request(logic [cfod_pkg::REQ_W-1:0] req, logic cls,
                                              logic [cfod_pkg::IO_TAG_W-1:0] tag);
    result_t                      r;
    bit                           found;
    int                           pick;
    logic [cfod_pkg::STAMP_W-1:0] best;
    r.status = cfod_pkg::ST_EMPTY;
    r.cls    = 1'b0;
    r.tag    = '0;
    found    = 0;
    pick     = 0;
    best     = '0;
    case (req)
      cfod_pkg::REQ_ENQ: begin
        if (ring_fill[cls] >= QDEPTH) begin
          r.status = cfod_pkg::ST_FULL;
        end else begin
          tag_ring[cls][ring_tail[cls]]   = tag;
          stamp_ring[cls][ring_tail[cls]] = next_stamp;
          next_stamp     = next_stamp + 1;
          ring_tail[cls] = (ring_tail[cls] + 1) % QDEPTH;
          ring_fill[cls]++;
          r.status = cfod_pkg::ST_OK;
        end
      end
      cfod_pkg::REQ_DEQ_ANY: begin
        // lowest class wins a tie on stamps
        for (int c = 0; c < NCLS; c++) begin
          if (ring_fill[c] != 0 && (!found || stamp_ring[c][ring_head[c]] < best)) begin
            found = 1;
            pick  = c;
            best  = stamp_ring[c][ring_head[c]];
          end
        end
      end
      cfod_pkg::REQ_DEQ_CLASS: begin
        found = (ring_fill[cls] != 0);
        pick  = cls;
      end
      default: ;
    endcase
    if (found) begin
      r.status = cfod_pkg::ST_OK;
      r.cls    = pick[0];
      r.tag    = tag_ring[pick][ring_head[pick]];
      ring_head[pick] = (ring_head[pick] + 1) % QDEPTH;
      ring_fill[pick]--;
    end
    return r;
  endfunction

  // Present one request, hold it until taken, then log its expected result
  task automatic send_req(logic [cfod_pkg::REQ_W-1:0] req, logic cls,
                          logic [cfod_pkg::IO_TAG_W-1:0] tag, bit typed, result_t want);
    result_t predicted;
    int      gap;
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_item_class <= cls;
    in_item_tag   <= tag;
    do @(posedge clk); while (in_stall);
    predicted = predict_request(req, cls, tag);
    pending_results.push_back(typed ? want : predicted);
    // sender bursts with random gaps in between
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(1, 12);
      burst_left = $urandom_range(0, 30);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic void add_row(logic [cfod_pkg::REQ_W-1:0] req, logic cls,
                                  logic [cfod_pkg::IO_TAG_W-1:0] tag, bit typed,
                                  cfod_pkg::status_t st, logic ocls,
                                  logic [cfod_pkg::IO_TAG_W-1:0] otag);
    dir_row_t row;
    row.req         = req;
    row.cls         = cls;
    row.tag         = tag;
    row.typed       = typed;
    row.want.status = st;
    row.want.cls    = ocls;
    row.want.tag    = otag;
    dir_table.push_back(row);
  endfunction

  // Receiver stall pattern, switching to a random style whenever its hold counter runs out
  int stall_mode = STALL_NONE;
  int stall_left = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(STALL_NONE, STALL_PERIOD);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_RANDOM: out_stall <= ($urandom_range(2) == 0);
      STALL_HEAVY:  out_stall <= ($urandom_range(3) != 0);
      STALL_PERIOD: out_stall <= (stall_tick % 4 == 0);
      default:      out_stall <= 1'b0;
    endcase
  end

  // Result checker: compare each taken result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, tag", out_tag, '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_status !== oldest_result.status)
          report_mismatch("status", out_status, oldest_result.status);
        if (out_class !== oldest_result.cls)
          report_mismatch("class", out_class, oldest_result.cls);
        if (out_tag !== oldest_result.tag)
          report_mismatch("tag", out_tag, oldest_result.tag);
      end
    end
  end

  // Stimulus
  initial begin
    int                            mix;
    int                            mix_left;
    int                            roll;
    logic [cfod_pkg::REQ_W-1:0]    req;
    logic [cfod_pkg::IO_TAG_W-1:0] tag;
    result_t                       none;

    none = '0;
    for (int c = 0; c < NCLS; c++) begin
      ring_head[c] = 0;
      ring_tail[c] = 0;
      ring_fill[c] = 0;
    end
    next_stamp = '0;

    // empty block, every request kind, then tag extremes across both classes
    add_row(cfod_pkg::REQ_DEQ_ANY,   1'b0, 16'h0000, 1, cfod_pkg::ST_EMPTY, 1'b0, 16'h0000);
    add_row(cfod_pkg::REQ_DEQ_CLASS, 1'b0, 16'h0000, 1, cfod_pkg::ST_EMPTY, 1'b0, 16'h0000);
    add_row(cfod_pkg::REQ_DEQ_CLASS, 1'b1, 16'hffff, 1, cfod_pkg::ST_EMPTY, 1'b0, 16'h0000);
    add_row(REQ_UNUSED,              1'b1, 16'hffff, 1, cfod_pkg::ST_EMPTY, 1'b0, 16'h0000);
    add_row(cfod_pkg::REQ_ENQ,       1'b0, 16'h0000, 1, cfod_pkg::ST_OK,    1'b0, 16'h0000);
    add_row(cfod_pkg::REQ_ENQ,       1'b1, 16'hffff, 1, cfod_pkg::ST_OK,    1'b0, 16'h0000);
    add_row(cfod_pkg::REQ_DEQ_ANY,   1'b1, 16'h0000, 1, cfod_pkg::ST_OK,    1'b0, 16'h0000);
    add_row(cfod_pkg::REQ_DEQ_ANY,   1'b0, 16'h0000, 1, cfod_pkg::ST_OK,    1'b1, 16'hffff);
    add_row(cfod_pkg::REQ_DEQ_ANY,   1'b0, 16'h0000, 1, cfod_pkg::ST_EMPTY, 1'b0, 16'h0000);
    // fill class 1 to the top, then one more is refused
    for (int i = 0; i < QDEPTH; i++)
      add_row(cfod_pkg::REQ_ENQ, 1'b1, 16'($urandom), 0, cfod_pkg::ST_OK, 1'b0, 16'h0000);
    add_row(cfod_pkg::REQ_ENQ, 1'b1, 16'h1234, 1, cfod_pkg::ST_FULL, 1'b0, 16'h0000);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i])
      send_req(dir_table[i].req, dir_table[i].cls, dir_table[i].tag,
               dir_table[i].typed, dir_table[i].want);

    // random traffic in mixes that push the queues full, drain them, or hover
    mix_left = 0;
    mix      = MIX_EVEN;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (mix_left == 0) begin
        mix      = $urandom_range(MIX_FILL, MIX_EVEN);
        mix_left = $urandom_range(30, 90);
      end
      mix_left--;
      roll = $urandom_range(99);
      case (mix)
        MIX_FILL:
          req = (roll < 70) ? cfod_pkg::REQ_ENQ :
                (roll < 84) ? cfod_pkg::REQ_DEQ_ANY :
                (roll < 97) ? cfod_pkg::REQ_DEQ_CLASS : REQ_UNUSED;
        MIX_DRAIN:
          req = (roll < 25) ? cfod_pkg::REQ_ENQ :
                (roll < 60) ? cfod_pkg::REQ_DEQ_ANY :
                (roll < 96) ? cfod_pkg::REQ_DEQ_CLASS : REQ_UNUSED;
        default:
          req = (roll < 47) ? cfod_pkg::REQ_ENQ :
                (roll < 72) ? cfod_pkg::REQ_DEQ_ANY :
                (roll < 96) ? cfod_pkg::REQ_DEQ_CLASS : REQ_UNUSED;
      endcase
      roll = $urandom_range(15);
      tag  = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hffff : 16'($urandom);
      send_req(req, 1'($urandom_range(1)), tag, 0, none);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("class_fifo_oldest_first_dequeue_core_tb: clean");
    end else begin
      $display("class_fifo_oldest_first_dequeue_core_tb: errors");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("class_fifo_oldest_first_dequeue_core_tb: errors");
    $finish;
  end

endmodule

// ===== class_fifo_oldest_first_dequeue_core.f =====
rtl/cfod_pkg.sv
rtl/cfod_ram.sv
rtl/cfod_queue.sv
rtl/cfod_pick.sv
rtl/class_fifo_oldest_first_dequeue_core.sv
tb/class_fifo_oldest_first_dequeue_core_tb.sv
